// File: rtl/choke_gate_event_queue_top_macros.svh
// assertion macros for the choke gate top level
// no dependencies; include by bare file name
`ifndef CHOKE_GATE_EVENT_QUEUE_TOP_MACROS_SVH
`define CHOKE_GATE_EVENT_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CGE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("choke gate assertion failed");

// next-cycle implication, disabled during reset
`define CGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("choke gate assertion failed");

`endif

// File: rtl/cge_pkg.sv
// types and constants for the choke gate event queue
// no dependencies
`timescale 1ns / 1ps

package cge_pkg;

  localparam int unsigned TIME_W      = 48;
  localparam int unsigned GAIN_W      = 17;
  localparam int unsigned COEFF_W     = 16;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned QUEUE_DEPTH = 64;

  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd454;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic [OFFSET_W-1:0]        event_offset;
    logic                       restore_flag;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic [GAIN_W-1:0]          gain_now;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] at;
    logic              restore;
  } entry_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TIME_W-1:0] at;
    logic              restore;
  } cell_ctrl_t;

endpackage

// File: rtl/cge_cell.sv
// one slot of the time-ordered event chain
// depends on cge_pkg
`timescale 1ns / 1ps

module cge_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cge_pkg::cell_ctrl_t ctrl_i,
  input  cge_pkg::entry_t     left_i,
  input  logic                left_open_i,
  input  logic                left_gt_i,
  input  cge_pkg::entry_t     right_i,
  output cge_pkg::entry_t     entry_o,
  output logic                open_o,
  output logic                gt_o
);

  logic                      valid_q;
  logic [cge_pkg::TIME_W-1:0] at_q;
  logic                      restore_q;
  logic                      own_gt;
  logic                      ins;

  assign own_gt = valid_q && (at_q > ctrl_i.at);
  assign ins    = left_open_i && (!valid_q || own_gt);
  assign open_o = valid_q && !own_gt;
  assign gt_o   = own_gt;

  assign entry_o = '{valid: valid_q, at: at_q, restore: restore_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.pop) begin
      valid_q <= right_i.valid;
    end else if (ctrl_i.push) begin
      if (ins) begin
        valid_q <= 1'b1;
      end else if (left_gt_i) begin
        valid_q <= left_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      at_q      <= right_i.at;
      restore_q <= right_i.restore;
    end else if (ctrl_i.push) begin
      if (ins) begin
        at_q      <= ctrl_i.at;
        restore_q <= ctrl_i.restore;
      end else if (left_gt_i) begin
        at_q      <= left_i.at;
        restore_q <= left_i.restore;
      end
    end
  end

endmodule

// File: rtl/cge_queue.sv
// row of event cells kept in time order, head at cell zero
// depends on cge_pkg and cge_cell
`timescale 1ns / 1ps

module cge_queue #(
  parameter int unsigned DEPTH = cge_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cge_pkg::cell_ctrl_t ctrl_i,
  output cge_pkg::entry_t     head_o,
  output logic                full_o
);

  cge_pkg::entry_t ent [DEPTH];
  logic            open_c [DEPTH];
  logic            gt_c [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cge_pkg::entry_t left_e;
    cge_pkg::entry_t right_e;
    logic            left_open;
    logic            left_gt;

    if (i == 0) begin : g_first
      assign left_e    = '0;
      assign left_open = 1'b1;
      assign left_gt   = 1'b0;
    end else begin : g_inner
      assign left_e    = ent[i-1];
      assign left_open = open_c[i-1];
      assign left_gt   = gt_c[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_more
      assign right_e = ent[i+1];
    end

    cge_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .left_i      (left_e),
      .left_open_i (left_open),
      .left_gt_i   (left_gt),
      .right_i     (right_e),
      .entry_o     (ent[i]),
      .open_o      (open_c[i]),
      .gt_o        (gt_c[i])
    );
  end

  assign head_o = ent[0];
  assign full_o = ent[DEPTH-1].valid;

endmodule

// File: rtl/choke_gate_event_queue_top.sv
// choke gate top level: event chain, gain sequencer and output register
// depends on cge_pkg, cge_queue and choke_gate_event_queue_top_macros.svh
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i/in_stall_o  | cge_pkg::in_word_t
//   out     | output    | out_valid_o/out_stall_i| cge_pkg::out_word_t
//   cfg     | input     | cfg_we_i               | decay coefficient, 16 bits
//
// an event word is placed into the cell chain at acceptance, unless the chain is full
// a tick holds the input stalled until its output word is loaded; due events are popped
// from the head first, one a cycle, then the gain is stepped and the samples scaled
// the head pop, the gain multiply and the sample multiply each own a state (S_DRAIN, S_MULT, S_SCALE)
// reset empties the chain, sets full gain with target one and sample time zero
// a stalled output holds the finished tick; event words are still taken while idle
`timescale 1ns / 1ps

`include "choke_gate_event_queue_top_macros.svh"

module choke_gate_event_queue_top #(
  parameter int unsigned QUEUE_DEPTH = cge_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cge_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cge_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_we_i,
  input  logic [cge_pkg::COEFF_W-1:0]         cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_MULT,
    S_STEP,
    S_SCALE,
    S_OUT
  } state_e;

  localparam int unsigned ProdW = cge_pkg::GAIN_W + cge_pkg::COEFF_W;
  localparam int unsigned MulW  = cge_pkg::SAMPLE_W + cge_pkg::GAIN_W + 1;

  state_e                          state_q;
  logic [cge_pkg::TIME_W-1:0]      time_q;
  logic [cge_pkg::GAIN_W-1:0]      gain_q;
  logic                            target_q;
  logic [cge_pkg::COEFF_W-1:0]     coeff_q;
  logic                            out_valid_q;
  cge_pkg::out_word_t              out_word_q;

  logic signed [cge_pkg::SAMPLE_W-1:0] left_q;
  logic signed [cge_pkg::SAMPLE_W-1:0] right_q;
  logic [cge_pkg::GAIN_W-1:0]          dist_q;
  logic [ProdW-1:0]                    prod_q;
  logic signed [MulW-1:0]              mul_l_q;
  logic signed [MulW-1:0]              mul_r_q;

  cge_pkg::cell_ctrl_t             ctrl;
  cge_pkg::entry_t                 head;
  logic                            full;
  logic                            in_acc;
  logic                            due;
  logic                            out_free;
  logic [cge_pkg::GAIN_W-1:0]      tgt;
  logic [cge_pkg::GAIN_W-1:0]      gain_gap;
  logic [cge_pkg::GAIN_W-1:0]      step;
  logic [cge_pkg::GAIN_W-1:0]      gain_next;
  logic signed [MulW-1:0]          rnd_l;
  logic signed [MulW-1:0]          rnd_r;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign due = head.valid && (head.at <= time_q);

  always_comb begin
    ctrl.push    = in_acc && (in_word_i.opcode == cge_pkg::OP_EVENT) && !full;
    ctrl.pop     = (state_q == S_DRAIN) && due;
    ctrl.at      = time_q + cge_pkg::TIME_W'(in_word_i.event_offset);
    ctrl.restore = in_word_i.restore_flag;
  end

  cge_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head),
    .full_o (full)
  );

  // gain step toward target, never past it, at least one lsb unless already there
  always_comb begin
    tgt      = target_q ? cge_pkg::GAIN_ONE : '0;
    gain_gap = (gain_q > tgt) ? (gain_q - tgt) : (tgt - gain_q);
    step     = prod_q[ProdW-1:cge_pkg::COEFF_W];
    if (step == '0) begin
      step = cge_pkg::GAIN_W'(1);
    end
    if (step > dist_q) begin
      step = dist_q;
    end
    gain_next = (gain_q > tgt) ? (gain_q - step) : (gain_q + step);
  end

  // round half up
  assign rnd_l = mul_l_q + MulW'(32768);
  assign rnd_r = mul_r_q + MulW'(32768);

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_word_i.opcode == cge_pkg::OP_TICK)) begin
      left_q  <= in_word_i.left_in;
      right_q <= in_word_i.right_in;
    end
    if (state_q == S_MULT) begin
      dist_q <= gain_gap;
      prod_q <= ProdW'(gain_gap) * ProdW'(coeff_q);
    end
    if (state_q == S_SCALE) begin
      mul_l_q <= MulW'(left_q) * $signed({1'b0, gain_q});
      mul_r_q <= MulW'(right_q) * $signed({1'b0, gain_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      gain_q      <= cge_pkg::GAIN_ONE;
      target_q    <= 1'b1;
      coeff_q     <= cge_pkg::COEFF_RESET;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        coeff_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_word_i.opcode == cge_pkg::OP_TICK)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (due) begin
            if (head.restore) begin
              gain_q   <= cge_pkg::GAIN_ONE;
              target_q <= 1'b1;
            end else begin
              target_q <= 1'b0;
            end
          end else begin
            state_q <= S_MULT;
          end
        end
        S_MULT: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          gain_q  <= gain_next;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_word_q.left_out  <= rnd_l[cge_pkg::SAMPLE_W+15:16];
            out_word_q.right_out <= rnd_r[cge_pkg::SAMPLE_W+15:16];
            out_word_q.gain_now  <= gain_q;
            time_q               <= time_q + cge_pkg::TIME_W'(1);
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `CGE_ASSERT_NOW(a_gain_range, clk_i, rst_ni, 1'b1, gain_q <= cge_pkg::GAIN_ONE)
  `CGE_ASSERT_NOW(a_pop_has_head, clk_i, rst_ni, ctrl.pop, head.valid && !ctrl.push)
  `CGE_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, ctrl.push, !full && state_q == S_IDLE)
  `CGE_ASSERT_NEXT(a_out_loaded, clk_i, rst_ni, state_q == S_OUT && out_free,
                   out_valid_o && state_q == S_IDLE)

endmodule
